// File: hdl/slot_handle_table_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot handle table
// Shared property forms, clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SLOT_HANDLE_TABLE_TOP_MACROS_SVH
`define SLOT_HANDLE_TABLE_TOP_MACROS_SVH

// When ante holds at an edge, cons must hold at the same edge.
`define SHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// When ante holds at an edge, cons must hold at the next edge.
`define SHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// Operation and status codes and word layouts of the slot handle table.
// ----------------------------------------------------------------------------
package sht_pkg;

    localparam int OP_W     = 2;
    localparam int INDEX_W  = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int RIDX_W   = 6;
    localparam int SIZE_W   = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NULL  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NONE  = 3'd5;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 7'd64;

    // Result of one table decision, handed from the decode to the response stage.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RIDX_W-1:0]   index;
        logic                use_rdata;
    } sht_resp_t;

endpackage

// File: hdl/slot_handle_table_top.sv
// ----------------------------------------------------------------------------
// slot_handle_table_top
// Table of SLOTS handles with add, remove, get and find-next operations.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Words                      Handshake
//  s_*       in         one request per word       s_tvalid / s_tready
//  m_*       out        one response per request   m_tvalid / m_tready
//  cfg_*     in         table_size write           cfg_we, no back-pressure
//
// A request is decoded in the cycle it is accepted, against the valid flags,
// and issues at most one value-memory access; in the response state its
// response loads into the output register with the read data once the
// output register is free. Input ready drops while in the response state.
// Reset clears every valid flag at once, so no clearing pass is needed.
// A stalled output word lets one more request in, whose response then waits.
//
`include "slot_handle_table_top_macros.svh"

module slot_handle_table_top #(
    parameter int SLOTS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Configuration: table_size.
    input  logic                          cfg_we,
    input  logic [sht_pkg::SIZE_W-1:0]    cfg_wdata,

    // Request stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [6:0] slot_index, [38:7] entry_value, [39] zero
    input  logic [sht_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] opcode
    input  logic [sht_pkg::OP_W-1:0]      s_tuser,

    // Response stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [5:0] result_index, [37:6] result_value, [39:38] zero
    output logic [sht_pkg::M_DATA_W-1:0]  m_tdata,
    // [2:0] status
    output logic [sht_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SZ_W  = (CNT_W > sht_pkg::SIZE_W) ? CNT_W : sht_pkg::SIZE_W;

    // Sequencer codes.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic                             state_reg, state_next;
    logic [sht_pkg::SIZE_W-1:0]       table_size_reg;
    logic [SLOTS-1:0]                 valid_reg, valid_next;

    // Value memory.
    logic [sht_pkg::VALUE_W-1:0]      mem [SLOTS];
    logic [sht_pkg::VALUE_W-1:0]      mem_rdata_reg;
    logic                             mem_we, mem_re;
    logic [IDX_W-1:0]                 mem_addr;

    // Request fields.
    logic [sht_pkg::OP_W-1:0]         in_op;
    logic [sht_pkg::INDEX_W-1:0]      in_index;
    logic [sht_pkg::VALUE_W-1:0]      in_value;
    logic                             s_accept;

    logic [SZ_W-1:0]                  act_size;
    logic [SZ_W-1:0]                  idx_ext;
    logic                             idx_in_range;
    logic [IDX_W-1:0]                 idx_addr;
    logic [SLOTS-1:0]                 free_vec, find_vec, search_vec;
    logic                             search_found;
    logic [IDX_W-1:0]                 search_pos;

    sht_pkg::sht_resp_t               resp_next, resp_reg;

    // Output register.
    logic                             m_valid_reg;
    logic                             out_load;
    logic [sht_pkg::STATUS_W-1:0]     m_status_reg;
    logic [sht_pkg::RIDX_W-1:0]       m_index_reg;
    logic [sht_pkg::VALUE_W-1:0]      m_value_reg;

    assign in_op    = s_tuser;
    assign in_index = s_tdata[sht_pkg::INDEX_W-1:0];
    assign in_value = s_tdata[sht_pkg::INDEX_W +: sht_pkg::VALUE_W];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // The active size is table_size clipped to the number of physical slots.
    always_comb begin
        if (SZ_W'(table_size_reg) > SZ_W'(SLOTS)) begin
            act_size = SZ_W'(SLOTS);
        end else begin
            act_size = SZ_W'(table_size_reg);
        end
    end

    assign idx_ext      = SZ_W'(in_index);
    assign idx_in_range = idx_ext < act_size;
    assign idx_addr     = idx_ext[IDX_W-1:0];

    // Candidate masks: empty slots below the size for add, occupied slots
    // from the start index up to the size for find-next.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            free_vec[i] = !valid_reg[i] && (SZ_W'(i) < act_size);
            find_vec[i] = valid_reg[i] && (SZ_W'(i) < act_size) && (SZ_W'(i) >= idx_ext);
        end
    end

    assign search_vec = (in_op == sht_pkg::OP_ADD) ? free_vec : find_vec;

    sht_first_set #(
        .WIDTH (SLOTS)
    ) u_first_set (
        .vec   (search_vec),
        .found (search_found),
        .pos   (search_pos)
    );

    // Request decode: status, flag update and memory access, decided in the cycle of acceptance.
    always_comb begin
        valid_next          = valid_reg;
        mem_we              = 1'b0;
        mem_re              = 1'b0;
        mem_addr            = idx_addr;
        resp_next.status    = sht_pkg::STAT_OK;
        resp_next.index     = '0;
        resp_next.use_rdata = 1'b0;
        unique case (in_op)
            sht_pkg::OP_ADD: begin
                mem_addr = search_pos;
                if (in_value == '0) begin
                    resp_next.status = sht_pkg::STAT_NULL;
                end else if (!search_found) begin
                    resp_next.status = sht_pkg::STAT_FULL;
                end else begin
                    resp_next.index = sht_pkg::RIDX_W'(search_pos);
                    mem_we          = s_accept;
                    if (s_accept) begin
                        valid_next[search_pos] = 1'b1;
                    end
                end
            end
            sht_pkg::OP_REMOVE: begin
                if (!idx_in_range) begin
                    resp_next.status = sht_pkg::STAT_RANGE;
                end else if (!valid_reg[idx_addr]) begin
                    resp_next.status = sht_pkg::STAT_EMPTY;
                end else if (s_accept) begin
                    valid_next[idx_addr] = 1'b0;
                end
            end
            sht_pkg::OP_GET: begin
                if (!idx_in_range) begin
                    resp_next.status = sht_pkg::STAT_RANGE;
                end else if (!valid_reg[idx_addr]) begin
                    resp_next.status = sht_pkg::STAT_EMPTY;
                end else begin
                    resp_next.use_rdata = 1'b1;
                    mem_re              = s_accept;
                end
            end
            sht_pkg::OP_FIND: begin
                mem_addr = search_pos;
                if (!search_found) begin
                    resp_next.status = sht_pkg::STAT_NONE;
                end else begin
                    resp_next.index     = sht_pkg::RIDX_W'(search_pos);
                    resp_next.use_rdata = 1'b1;
                    mem_re              = s_accept;
                end
            end
            default: begin
                resp_next.status = sht_pkg::STAT_NONE;
            end
        endcase
    end

    // The response of the request in flight loads once the output is free.
    assign out_load = (state_reg == S_RESP) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            table_size_reg <= sht_pkg::TABLE_SIZE_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_we) begin
                table_size_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Value memory: at most one access per request, registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= in_value;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            resp_reg <= resp_next;
        end
        if (out_load) begin
            m_status_reg <= resp_reg.status;
            m_index_reg  <= resp_reg.index;
            m_value_reg  <= resp_reg.use_rdata ? mem_rdata_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = sht_pkg::M_DATA_W'({m_value_reg, m_index_reg});

    // An accepted request always moves the sequencer to the response state.
    `SHT_ASSERT_NEXT(a_accept_to_resp, s_accept, state_reg == S_RESP, "no response cycle")
    // An add that writes a value marks that slot occupied.
    `SHT_ASSERT_NEXT(a_write_sets_valid, mem_we, valid_reg[$past(mem_addr)], "slot left empty")
    // A new response appears only after a response cycle.
    `SHT_ASSERT_NOW(a_resp_origin, $rose(m_tvalid), $past(state_reg) == S_RESP, "stray response")

endmodule

// File: hdl/sht_first_set.sv
// ----------------------------------------------------------------------------
// sht_first_set
// Finds the lowest set bit of a vector and returns its position.
// ----------------------------------------------------------------------------
module sht_first_set #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0]         vec,
    output logic                     found,
    output logic [$clog2(WIDTH)-1:0] pos
);

    localparam int POS_W = $clog2(WIDTH);

    logic [WIDTH-1:0] lowest;

    // Two's complement trick keeps only the lowest set bit.
    assign lowest = vec & (~vec + WIDTH'(1));
    assign found  = |vec;

    // One-hot to binary: each position contributes its own number.
    always_comb begin
        pos = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (lowest[i]) begin
                pos = pos | POS_W'(i);
            end
        end
    end

endmodule
